FILE: rtl/depq_pkg.sv
// Package for the double-ended priority queue: command codes, cell control
// struct, data width, default capacity and the order key function.
// No dependencies.
`default_nettype none

package depq_pkg;

    localparam int unsigned DATA_W           = 32;
    localparam int unsigned DEFAULT_CAPACITY = 64;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DEL_MAX = 2'd1,
        CMD_DEL_MIN = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    // Per-cycle instruction broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic del_min;
    } t_cell_op;

    // Flipping the sign bit turns signed order into unsigned order.
    function automatic logic [DATA_W-1:0] order_key(input logic [DATA_W-1:0] v);
        order_key = {~v[DATA_W-1], v[DATA_W-2:0]};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/depq_intf.sv
// Handshake interfaces for the command channel and the result channel.
// Depends on depq_pkg.
`default_nettype none

interface depq_cmd_if;
    import depq_pkg::*;

    logic                     valid;
    logic                     ready;
    t_cmd                     cmd;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, cmd, value, input ready);
    modport sink   (input valid, cmd, value, output ready);
endinterface

interface depq_res_if;
    import depq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] max_value;
    logic signed [DATA_W-1:0] min_value;
    logic                     is_empty;
    logic                     overflow;

    modport source (output valid, max_value, min_value, is_empty, overflow, input ready);
    modport sink   (input valid, max_value, min_value, is_empty, overflow, output ready);
endinterface

`default_nettype wire

FILE: rtl/depq_cell.sv
// One cell of the sorted register chain: holds one value, compares it with
// the value being inserted and shifts with its neighbours. Depends on depq_pkg.
`default_nettype none

module depq_cell #(
    parameter int unsigned CAPACITY = depq_pkg::DEFAULT_CAPACITY,
    parameter int unsigned CELL_IDX = 0,
    localparam int unsigned CNT_W   = $clog2(CAPACITY + 1)
) (
    input  wire                             i_clk,
    input  depq_pkg::t_cell_op              i_op,
    input  wire  [depq_pkg::DATA_W-1:0]     i_ins_value,
    input  wire  [CNT_W-1:0]                i_count,
    input  wire  [depq_pkg::DATA_W-1:0]     i_left_value,
    input  wire                             i_left_gt,
    input  wire  [depq_pkg::DATA_W-1:0]     i_right_value,
    input  wire                             i_right_occ,
    output logic [depq_pkg::DATA_W-1:0]     o_value,
    output logic                            o_gt,
    output logic                            o_occ,
    output logic [depq_pkg::DATA_W-1:0]     o_top_value
);
    import depq_pkg::*;

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;

    // A free cell counts as greater, so an insert fills the first free cell.
    assign o_occ = CNT_W'(CELL_IDX) < i_count;
    assign o_gt  = !o_occ || (order_key(r_value) > order_key(i_ins_value));

    assign o_value     = r_value;
    assign o_top_value = (o_occ && !i_right_occ) ? r_value : '0;

    always_comb begin
        n_value = r_value;
        if (i_op.insert) begin
            if (o_gt) begin
                n_value = i_left_gt ? i_left_value : i_ins_value;
            end
        end else if (i_op.del_min) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

FILE: rtl/double_ended_priority_queue_core.sv
// Top level of the double-ended priority queue: a chain of sorted cells,
// the fill count and the registered result stage.
// Depends on depq_pkg, depq_intf and depq_cell.
//
//   Channel  Direction  Transaction content
//   i_in     sink       cmd, value
//   o_out    source     max_value, min_value, is_empty, overflow
//
// In each transaction the chain shifts at the accepting edge, then the largest
// value is picked from the cell that marks the top of the fill and registered
// with the smallest one from the first cell.
// A new transaction is taken once the previous result has gone or is leaving.
// A stall on o_out holds the result and blocks i_in. Reset empties the store
// by clearing the fill count alone; no clearing pass is needed.
`default_nettype none

module double_ended_priority_queue_core #(
    parameter int unsigned CAPACITY = depq_pkg::DEFAULT_CAPACITY
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    depq_cmd_if.sink    i_in,
    depq_res_if.source  o_out
);
    import depq_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_busy;
    logic              r_ovf;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_max;
    logic [DATA_W-1:0] r_min;
    logic              r_empty;
    logic              r_out_ovf;

    logic              w_accept;
    logic              w_full;
    t_cell_op          w_op;
    logic [DATA_W-1:0] w_max;

    logic [DATA_W-1:0] w_value     [CAPACITY];
    logic [DATA_W-1:0] w_top_value [CAPACITY];
    logic              w_gt        [CAPACITY];
    logic              w_occ       [CAPACITY];

    assign i_in.ready = !r_busy && (!r_out_valid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = r_count == CNT_W'(CAPACITY);

    always_comb begin
        w_op.insert  = 1'b0;
        w_op.del_min = 1'b0;
        n_count      = r_count;
        if (w_accept) begin
            unique case (i_in.cmd)
                CMD_INSERT: begin
                    if (!w_full) begin
                        w_op.insert = 1'b1;
                        n_count     = r_count + 1'b1;
                    end
                end
                CMD_DEL_MAX: begin
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                end
                CMD_DEL_MIN: begin
                    if (r_count != '0) begin
                        w_op.del_min = 1'b1;
                        n_count      = r_count - 1'b1;
                    end
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_left_value;
        logic              w_left_gt;
        logic [DATA_W-1:0] w_right_value;
        logic              w_right_occ;

        if (g == 0) begin : g_first
            assign w_left_value = '0;
            assign w_left_gt    = 1'b0;
        end else begin : g_inner_l
            assign w_left_value = w_value[g-1];
            assign w_left_gt    = w_gt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_value = w_value[g];
            assign w_right_occ   = 1'b0;
        end else begin : g_inner_r
            assign w_right_value = w_value[g+1];
            assign w_right_occ   = w_occ[g+1];
        end

        depq_cell #(
            .CAPACITY (CAPACITY),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_op          (w_op),
            .i_ins_value   (i_in.value),
            .i_count       (r_count),
            .i_left_value  (w_left_value),
            .i_left_gt     (w_left_gt),
            .i_right_value (w_right_value),
            .i_right_occ   (w_right_occ),
            .o_value       (w_value[g]),
            .o_gt          (w_gt[g]),
            .o_occ         (w_occ[g]),
            .o_top_value   (w_top_value[g])
        );
    end

    // At most one cell marks the top, so an OR over the cells selects it.
    always_comb begin
        w_max = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_max = w_max | w_top_value[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_busy <= 1'b1;
                r_ovf  <= (i_in.cmd == CMD_INSERT) && w_full;
            end else if (r_busy) begin
                r_busy <= 1'b0;
            end
            if (r_busy) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_max     <= w_max;
            r_min     <= (r_count != '0) ? w_value[0] : '0;
            r_empty   <= r_count == '0;
            r_out_ovf <= r_ovf;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.max_value = r_max;
    assign o_out.min_value = r_min;
    assign o_out.is_empty  = r_empty;
    assign o_out.overflow  = r_out_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("Fill count exceeds the capacity.");

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy && r_out_valid)
        else $error("Result not registered one cycle after a transaction.");

    a_empty_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_busy) |-> (r_empty == (r_count == '0)))
        else $error("Empty flag disagrees with the fill count.");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_busy && r_out_ovf) |-> w_full)
        else $error("Overflow reported while the store is not full.");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_priority_queue_core: random and directed commands
// are checked against a sorted-queue predictor, with bursty sending and a patterned sink stall.
// Depends on depq_pkg, depq_intf and the RTL of the core.

module tb_top;
    import depq_pkg::*;

    localparam int STORE_DEPTH    = DEFAULT_CAPACITY;
    localparam int TARGET_ITEMS   = 1800;
    localparam int STALL_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic signed [DATA_W-1:0] max_value;
        logic signed [DATA_W-1:0] min_value;
        logic                     is_empty;
        logic                     overflow;
    } t_queue_report;

    typedef struct {
        t_cmd                     op;
        logic signed [DATA_W-1:0] operand;
        bit                       hold_for_drain;
    } t_command_item;

    typedef enum int {
        SEG_FILL,
        SEG_DRAIN,
        SEG_MIXED,
        SEG_NOISE
    } t_segment_kind;

    logic i_clk;
    logic i_rst_n;

    depq_cmd_if in_ch ();
    depq_res_if out_ch ();

    double_ended_priority_queue_core #(
        .CAPACITY (STORE_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_command_item            pending_commands[$];
    t_queue_report            expected_reports[$];
    logic signed [DATA_W-1:0] held_values[$];

    int items_accepted;
    int reports_checked;
    int mismatch_count;
    int peak_fill;
    int dropped_inserts;
    int empty_deletes;
    int send_burst_left;
    int send_gap_left;
    int sink_mode;
    int sink_mode_left;
    int sink_tick;
    int idle_cycles;

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.cmd    = CMD_NOP;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_queue_report apply_command(t_cmd op,
                                                    logic signed [DATA_W-1:0] operand);
        t_queue_report outcome;
        int            slot;
        outcome.overflow = 1'b0;
        case (op)
            CMD_INSERT: begin
                if (held_values.size() >= STORE_DEPTH) begin
                    outcome.overflow = 1'b1;
                    dropped_inserts++;
                end else begin
                    slot = held_values.size();
                    while (slot > 0 && held_values[slot-1] > operand) slot--;
                    held_values.insert(slot, operand);
                end
            end
            CMD_DEL_MAX: begin
                if (held_values.size() == 0) empty_deletes++;
                else held_values.delete(held_values.size() - 1);
            end
            CMD_DEL_MIN: begin
                if (held_values.size() == 0) empty_deletes++;
                else void'(held_values.pop_front());
            end
            default: ;
        endcase
        if (held_values.size() > peak_fill) peak_fill = held_values.size();
        if (held_values.size() == 0) begin
            outcome.max_value = '0;
            outcome.min_value = '0;
            outcome.is_empty  = 1'b1;
        end else begin
            outcome.max_value = held_values[held_values.size()-1];
            outcome.min_value = held_values[0];
            outcome.is_empty  = 1'b0;
        end
        return outcome;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_operand();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return $urandom;
        if (roll < 70) return $signed(DATA_W'($urandom_range(0, 8))) - 4;
        if (roll < 85) begin
            case ($urandom_range(0, 4))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'sd0;
                3: return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
    endfunction

    function automatic void queue_command(t_cmd op, logic signed [DATA_W-1:0] operand,
                                          bit hold_for_drain = 1'b0);
        t_command_item item;
        item.op             = op;
        item.operand        = operand;
        item.hold_for_drain = hold_for_drain;
        pending_commands.insert(pending_commands.size(), item);
    endfunction

    function automatic t_cmd pick_op(t_segment_kind kind);
        int roll;
        roll = $urandom_range(0, 99);
        case (kind)
            SEG_FILL: begin
                if (roll < 88) return CMD_INSERT;
                return (roll < 94) ? CMD_DEL_MAX : CMD_DEL_MIN;
            end
            SEG_DRAIN: begin
                if (roll < 15) return CMD_INSERT;
                return (roll < 57) ? CMD_DEL_MAX : CMD_DEL_MIN;
            end
            SEG_MIXED: begin
                if (roll < 50) return CMD_INSERT;
                return (roll < 75) ? CMD_DEL_MAX : CMD_DEL_MIN;
            end
            default: begin
                if (roll < 30) return CMD_INSERT;
                if (roll < 50) return CMD_DEL_MAX;
                return (roll < 70) ? CMD_DEL_MIN : CMD_NOP;
            end
        endcase
    endfunction

    initial begin
        int            counted;
        int            segment;
        int            seg_len;
        t_segment_kind kind;
        t_cmd          op;

        queue_command(CMD_DEL_MAX, 32'sh7FFF_FFFF);
        queue_command(CMD_DEL_MIN, 32'sh8000_0000);
        queue_command(CMD_NOP, -32'sd1);
        queue_command(CMD_INSERT, 32'sh7FFF_FFFF);
        queue_command(CMD_INSERT, 32'sh8000_0000);
        queue_command(CMD_INSERT, 32'sd0);
        queue_command(CMD_INSERT, -32'sd1);
        queue_command(CMD_INSERT, -32'sd1);
        queue_command(CMD_INSERT, 32'sd1);
        queue_command(CMD_NOP, 32'sh5555_AAAA);
        queue_command(CMD_DEL_MAX, 32'sd0);
        queue_command(CMD_DEL_MIN, 32'sd0);
        queue_command(CMD_DEL_MIN, -32'sd1);
        queue_command(CMD_DEL_MAX, 32'sd0);
        queue_command(CMD_DEL_MAX, 32'sd0);
        queue_command(CMD_DEL_MIN, 32'sd0);
        queue_command(CMD_DEL_MIN, 32'sd0);
        queue_command(CMD_INSERT, 32'sh8000_0000);
        queue_command(CMD_INSERT, 32'sh8000_0000);
        queue_command(CMD_DEL_MAX, 32'sd0);
        queue_command(CMD_DEL_MAX, 32'sd0);

        counted = 0;
        segment = 0;
        while (counted < TARGET_ITEMS) begin
            if (segment == 0) kind = SEG_FILL;
            else if (segment == 1) kind = SEG_DRAIN;
            else kind = t_segment_kind'($urandom_range(0, 3));
            seg_len = (segment == 0) ? 90 : $urandom_range(20, 120);
            for (int n = 0; n < seg_len; n++) begin
                op = pick_op(kind);
                queue_command(op, pick_operand(),
                              n == 0 && (segment == 0 || $urandom_range(0, 3) == 0));
                if (op != CMD_NOP) counted++;
            end
            segment++;
        end

        do @(posedge i_clk);
        while (!i_rst_n);
        do @(posedge i_clk);
        while (pending_commands.size() != 0 || in_ch.valid
               || items_accepted > reports_checked);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d commands with a peak fill of %0d of %0d entries.",
                 items_accepted, peak_fill, STORE_DEPTH);
        $display("%0d dropped inserts, %0d deletes on an empty store, %0d mismatches.",
                 dropped_inserts, empty_deletes, mismatch_count);
        if (mismatch_count == 0 && expected_reports.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Command driver: presents queued transactions in bursts separated by random gaps.
    always @(posedge i_clk) begin
        int in_flight;
        if (!i_rst_n) begin
            in_ch.valid     <= 1'b0;
            items_accepted  <= 0;
            send_burst_left <= $urandom_range(1, 48);
            send_gap_left   <= 0;
        end else begin
            in_flight = items_accepted - reports_checked;
            if (in_ch.valid && in_ch.ready) begin
                expected_reports.insert(expected_reports.size(),
                                        apply_command(in_ch.cmd, in_ch.value));
                items_accepted <= items_accepted + 1;
                in_flight++;
            end
            if (out_ch.valid && out_ch.ready) in_flight--;
            if (!(in_ch.valid && !in_ch.ready)) begin
                if (send_gap_left != 0) begin
                    send_gap_left <= send_gap_left - 1;
                    in_ch.valid   <= 1'b0;
                end else if (pending_commands.size() == 0
                             || (pending_commands[0].hold_for_drain && in_flight != 0)) begin
                    in_ch.valid <= 1'b0;
                end else begin
                    in_ch.valid <= 1'b1;
                    in_ch.cmd   <= pending_commands[0].op;
                    in_ch.value <= pending_commands[0].operand;
                    void'(pending_commands.pop_front());
                    if (send_burst_left <= 1) begin
                        send_burst_left <= $urandom_range(1, 48);
                        send_gap_left   <= ($urandom_range(0, 3) == 0) ? 0
                                                                       : $urandom_range(1, 14);
                    end else begin
                        send_burst_left <= send_burst_left - 1;
                    end
                end
            end
        end
    end

    task automatic check_field(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (want !== got) begin
            if (mismatch_count < REPORT_LIMIT)
                $display("Mismatch on %s in result %0d: expected %0d, got %0d",
                         field, reports_checked, $signed(want), $signed(got));
            mismatch_count++;
        end
    endtask

    // Result monitor: checks each transaction and stalls the sink on a changing pattern.
    always @(posedge i_clk) begin
        t_queue_report want;
        if (!i_rst_n) begin
            out_ch.ready    <= 1'b0;
            reports_checked <= 0;
            mismatch_count  <= 0;
            sink_mode       <= 0;
            sink_mode_left  <= 0;
            sink_tick       <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                reports_checked <= reports_checked + 1;
                if (expected_reports.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("Result with no command outstanding: max %0d min %0d",
                                 out_ch.max_value, out_ch.min_value);
                    mismatch_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("max_value", want.max_value, out_ch.max_value);
                    check_field("min_value", want.min_value, out_ch.min_value);
                    check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(out_ch.is_empty));
                    check_field("overflow", DATA_W'(want.overflow), DATA_W'(out_ch.overflow));
                end
            end
            sink_tick <= sink_tick + 1;
            if (sink_mode_left == 0) begin
                sink_mode      <= $urandom_range(0, 3);
                sink_mode_left <= $urandom_range(16, 160);
            end else begin
                sink_mode_left <= sink_mode_left - 1;
            end
            case (sink_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= $urandom_range(0, 1);
                2: out_ch.ready <= sink_tick[0];
                default: out_ch.ready <= (sink_tick[3:0] == 4'hF);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
